/* sv/ckwb_pkg.sv */
// shared types and constants for the chroma key wedge blend pipeline
package ckwb_pkg;

    localparam int NUM_STAGES = 7;

    typedef logic [NUM_STAGES-1:0] t_stage_en;

    typedef enum logic [2:0] {
        MODE_SOFTBURN     = 3'd0,
        MODE_DODGE        = 3'd1,
        MODE_MULTIPLY     = 3'd2,
        MODE_BURN         = 3'd3,
        MODE_LIGHTEN_BURN = 3'd4,
        MODE_SUBTRACT     = 3'd5,
        MODE_LINEAR_BURN  = 3'd6,
        MODE_OVERLAY      = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        CFG_KEY_MAGNITUDE = 3'd0,
        CFG_KEY_COSINE    = 3'd1,
        CFG_KEY_SINE      = 3'd2,
        CFG_INV_SLOPE     = 3'd3,
        CFG_ALPHA_GAIN    = 3'd4,
        CFG_BLACK_CLIP    = 3'd5,
        CFG_BLEND_SELECT  = 3'd6,
        CFG_SWAP_LAYERS   = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic        [19:0] key_magnitude;
        logic signed [13:0] key_cosine;
        logic signed [13:0] key_sine;
        logic        [15:0] wedge_inverse_slope;
        logic        [15:0] alpha_gain;
        logic        [19:0] black_clip;
        t_mode              blend_select;
        logic               swap_layers;
    } t_cfg;

    typedef struct packed {
        logic [7:0] y;
        logic [7:0] cb;
        logic [7:0] cr;
    } t_pixel;

    localparam logic [7:0] FULL = 8'd255;

endpackage

/* sv/ckwb_if.sv */
// pixel stream channels: pixel pair in, blended pixel out
interface ckwb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] main_y;
    logic [7:0] main_cb;
    logic [7:0] main_cr;
    logic [7:0] second_y;
    logic [7:0] second_cb;
    logic [7:0] second_cr;

    modport source(output valid, main_y, main_cb, main_cr, second_y, second_cb, second_cr,
                   input ready);
    modport sink(input valid, main_y, main_cb, main_cr, second_y, second_cb, second_cr,
                 output ready);
endinterface

interface ckwb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_y;
    logic [7:0] out_cb;
    logic [7:0] out_cr;

    modport source(output valid, out_y, out_cb, out_cr, input ready);
    modport sink(input valid, out_y, out_cb, out_cr, output ready);
endinterface

/* sv/chroma_key_wedge_blend.sv */
// top level: chroma key with wedge distance and luma blend modes, seven stage pipeline
//
//  channel   dir  handshake                 payload
//  i_pix     in   valid / ready             main_y/cb/cr, second_y/cb/cr
//  o_pix     out  valid / ready             out_y, out_cb, out_cr
//  cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  one pixel pair per clock unless o_pix stalls the pipeline
//  the depth is set by the 16 step luma divider, four restoring steps per stage
//  each full stage holds while its successor is full and stalled, so bubbles close up
//  and o_pix is a plain output register
//  reset clears the stage valid bits and loads the register defaults
//  configuration is always ready; later stages read the registers live, so write
//  them only while the pipeline is empty
module chroma_key_wedge_blend (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ckwb_in_if.sink            i_pix,
    ckwb_out_if.source         o_pix,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [19:0]        i_cfg_data
);

    ckwb_pkg::t_cfg      r_cfg;
    ckwb_pkg::t_stage_en en;
    logic [ckwb_pkg::NUM_STAGES-1:0] r_valid;
    ckwb_pkg::t_pixel    in_main, in_second, mid_main, mid_mix, res;
    logic [7:0]          alpha;

    assign o_cfg_ready = 1'b1;

    // register file, written by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_magnitude       <= 20'd4096;
            r_cfg.key_cosine          <= 14'sd4096;
            r_cfg.key_sine            <= 14'sd0;
            r_cfg.wedge_inverse_slope <= 16'd4096;
            r_cfg.alpha_gain          <= 16'd65280;
            r_cfg.black_clip          <= 20'd0;
            r_cfg.blend_select        <= ckwb_pkg::MODE_BURN;
            r_cfg.swap_layers         <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (ckwb_pkg::t_cfg_index'(i_cfg_index))
                ckwb_pkg::CFG_KEY_MAGNITUDE: r_cfg.key_magnitude <= i_cfg_data;
                ckwb_pkg::CFG_KEY_COSINE:    r_cfg.key_cosine    <= i_cfg_data[13:0];
                ckwb_pkg::CFG_KEY_SINE:      r_cfg.key_sine      <= i_cfg_data[13:0];
                ckwb_pkg::CFG_INV_SLOPE:     r_cfg.wedge_inverse_slope <= i_cfg_data[15:0];
                ckwb_pkg::CFG_ALPHA_GAIN:    r_cfg.alpha_gain    <= i_cfg_data[15:0];
                ckwb_pkg::CFG_BLACK_CLIP:    r_cfg.black_clip    <= i_cfg_data;
                ckwb_pkg::CFG_BLEND_SELECT:
                    r_cfg.blend_select <= ckwb_pkg::t_mode'(i_cfg_data[2:0]);
                ckwb_pkg::CFG_SWAP_LAYERS:   r_cfg.swap_layers   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // a stage loads when empty or when its content moves on
    always_comb begin
        en[ckwb_pkg::NUM_STAGES-1] = !r_valid[ckwb_pkg::NUM_STAGES-1] || o_pix.ready;
        for (int k = ckwb_pkg::NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (en[0]) begin
                r_valid[0] <= i_pix.valid;
            end
            for (int k = 1; k < ckwb_pkg::NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    assign i_pix.ready = en[0];

    assign in_main   = '{y: i_pix.main_y, cb: i_pix.main_cb, cr: i_pix.main_cr};
    assign in_second = '{y: i_pix.second_y, cb: i_pix.second_cb, cr: i_pix.second_cr};

    // key alpha from the main pixel chroma, ready after stage five
    ckwb_key u_key (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_cb    (i_pix.main_cb),
        .i_cr    (i_pix.main_cr),
        .o_alpha (alpha)
    );

    // foreground and background mix, aligned with the alpha
    ckwb_mix u_mix (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_cfg    (r_cfg),
        .i_main   (in_main),
        .i_second (in_second),
        .o_main   (mid_main),
        .o_mix    (mid_mix)
    );

    // blend the main pixel over the mix, last stage is the output register
    ckwb_over u_over (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_alpha (alpha),
        .i_main  (mid_main),
        .i_mix   (mid_mix),
        .o_pixel (res)
    );

    assign o_pix.valid  = r_valid[ckwb_pkg::NUM_STAGES-1];
    assign o_pix.out_y  = res.y;
    assign o_pix.out_cb = res.cb;
    assign o_pix.out_cr = res.cr;

endmodule

/* sv/ckwb_key.sv */
// key alpha path: chroma rotation, wedge distance, gain and clamp over five stages
module ckwb_key (
    input  logic              i_clk,
    input  ckwb_pkg::t_stage_en i_en,
    input  ckwb_pkg::t_cfg    i_cfg,
    input  logic [7:0]        i_cb,
    input  logic [7:0]        i_cr,
    output logic [7:0]        o_alpha
);

    logic signed [7:0]  uc, vc;
    logic signed [21:0] r_ucc, r_vcs, r_vcc, r_ucs;
    logic signed [22:0] n_sx, n_sy;
    logic signed [10:0] r_xx;
    logic signed [10:0] n_yy_s;
    logic        [9:0]  r_yy;
    logic        [25:0] n_yslope;
    logic signed [27:0] n_dist, r_dist;
    logic signed [28:0] n_diff;
    logic signed [45:0] r_prod;
    logic signed [25:0] n_sh;
    logic        [7:0]  r_alpha;

    // offset binary to two's complement
    assign uc = {~i_cb[7], i_cb[6:0]};
    assign vc = {~i_cr[7], i_cr[6:0]};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ucc <= uc * i_cfg.key_cosine;
            r_vcs <= vc * i_cfg.key_sine;
            r_vcc <= vc * i_cfg.key_cosine;
            r_ucs <= uc * i_cfg.key_sine;
        end
    end

    assign n_sx   = 23'(r_ucc) + 23'(r_vcs);
    assign n_sy   = 23'(r_vcc) - 23'(r_ucs);
    assign n_yy_s = n_sy[22:12];

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_xx <= n_sx[22:12];
            r_yy <= n_yy_s[10] ? 10'(-n_yy_s) : 10'(n_yy_s);
        end
    end

    assign n_yslope = r_yy * i_cfg.wedge_inverse_slope;
    assign n_dist   = 28'(signed'({1'b0, i_cfg.key_magnitude}))
                    - (28'(r_xx) <<< 12)
                    + 28'(signed'({1'b0, n_yslope}));

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_dist <= n_dist;
        end
    end

    assign n_diff = 29'(r_dist) - 29'(signed'({1'b0, i_cfg.black_clip}));

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_prod <= n_diff * signed'({1'b0, i_cfg.alpha_gain});
        end
    end

    assign n_sh = r_prod[45:20];

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            if (n_sh[25]) begin
                r_alpha <= 8'd0;
            end else if (n_sh > 26'sd255) begin
                r_alpha <= ckwb_pkg::FULL;
            end else begin
                r_alpha <= n_sh[7:0];
            end
        end
    end

    assign o_alpha = r_alpha;

endmodule

/* sv/ckwb_mix.sv */
// layer mix path: luma blend modes with a pipelined divider, chroma weighting
module ckwb_mix (
    input  logic                i_clk,
    input  ckwb_pkg::t_stage_en i_en,
    input  ckwb_pkg::t_cfg      i_cfg,
    input  ckwb_pkg::t_pixel    i_main,
    input  ckwb_pkg::t_pixel    i_second,
    output ckwb_pkg::t_pixel    o_main,
    output ckwb_pkg::t_pixel    o_mix
);

    localparam int DIV_STAGES = 4;

    typedef struct packed {
        ckwb_pkg::t_mode mode;
        logic            zero;
        logic            hi;
        logic [7:0]      direct;
    } t_ctl;

    typedef struct packed {
        ckwb_pkg::t_pixel main;
        logic [7:0]       lcb;
        logic [7:0]       lcr;
    } t_carry;

    // four restoring steps: remainder in [24:16], dividend then quotient in [15:0]
    function automatic logic [24:0] div4(input logic [24:0] st, input logic [7:0] den);
        logic [24:0] s;
        s = st;
        for (int i = 0; i < 4; i++) begin
            s = {s[23:0], 1'b0};
            if (s[24:16] >= {1'b0, den}) begin
                s[24:16] = s[24:16] - {1'b0, den};
                s[0]     = 1'b1;
            end
        end
        return s;
    endfunction

    function automatic logic [7:0] mix_c(input logic signed [17:0] p, input logic [7:0] fc);
        logic signed [10:0] s;
        s = 11'(p >>> 8) + 11'(signed'({1'b0, fc}));
        if (s[10]) begin
            return 8'd0;
        end else if (s > 11'sd255) begin
            return ckwb_pkg::FULL;
        end
        return s[7:0];
    endfunction

    logic [7:0]  fy, fcb, fcr, by, bcb, bcr, nb;
    logic [7:0]  ma, mb, n_den, n_add;
    logic [8:0]  s_ab;
    logic [9:0]  s_a2b;

    ckwb_pkg::t_mode   r_op_mode;
    logic              r_op_zero, r_op_hi;
    logic [7:0]        r_op_add, r_op_den;
    logic [15:0]       r_op_prod;
    logic signed [17:0] r_op_cbp, r_op_crp;
    logic [7:0]        r_op_fcb, r_op_fcr;
    ckwb_pkg::t_pixel  r_op_main;

    logic [24:0] r_st  [DIV_STAGES];
    logic [7:0]  r_den [DIV_STAGES];
    t_ctl        r_ctl [DIV_STAGES];
    t_carry      r_car [DIV_STAGES];

    logic [7:0]  n_direct;
    logic [15:0] q;
    logic [7:0]  qsat, ly;

    always_comb begin
        fy  = i_cfg.swap_layers ? i_second.y  : i_main.y;
        fcb = i_cfg.swap_layers ? i_second.cb : i_main.cb;
        fcr = i_cfg.swap_layers ? i_second.cr : i_main.cr;
        by  = i_cfg.swap_layers ? i_main.y    : i_second.y;
        bcb = i_cfg.swap_layers ? i_main.cb   : i_second.cb;
        bcr = i_cfg.swap_layers ? i_main.cr   : i_second.cr;
        nb  = ckwb_pkg::FULL - by;
        s_ab  = {1'b0, fy} + {1'b0, by};
        s_a2b = {2'b0, fy} + {1'b0, by, 1'b0};
        // one luma multiplier shared across modes, operands picked by mode
        ma    = fy;
        mb    = by;
        n_den = nb;
        n_add = 8'd0;
        case (i_cfg.blend_select)
            ckwb_pkg::MODE_DODGE: begin
                ma    = nb;
                mb    = nb;
                n_den = fy;
            end
            ckwb_pkg::MODE_BURN: begin
                mb = fy;
            end
            ckwb_pkg::MODE_LIGHTEN_BURN: begin
                ma = by;
                mb = ckwb_pkg::FULL;
            end
            ckwb_pkg::MODE_OVERLAY: begin
                if (by[7]) begin
                    ma = nb;
                    mb = ckwb_pkg::FULL - fy;
                end
            end
            ckwb_pkg::MODE_SUBTRACT: begin
                n_add = (s_ab >= 9'd255) ? 8'(s_ab - 9'd255) : 8'd0;
            end
            ckwb_pkg::MODE_LINEAR_BURN: begin
                if (s_a2b >= 10'd510) begin
                    n_add = ckwb_pkg::FULL;
                end else if (s_a2b >= 10'd255) begin
                    n_add = 8'(s_a2b - 10'd255);
                end
            end
            ckwb_pkg::MODE_SOFTBURN: begin
                n_add = (s_ab <= 9'd255) ? s_ab[7:0] : 8'(9'd510 - s_ab);
            end
            default: begin
                n_add = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_op_mode <= i_cfg.blend_select;
            r_op_zero <= (n_den == 8'd0);
            r_op_hi   <= by[7];
            r_op_add  <= n_add;
            r_op_den  <= n_den;
            r_op_prod <= ma * mb;
            r_op_cbp  <= signed'({1'b0, by}) * (signed'({1'b0, fcb}) - signed'({1'b0, bcb}));
            r_op_crp  <= signed'({1'b0, by}) * (signed'({1'b0, fcr}) - signed'({1'b0, bcr}));
            r_op_fcb  <= fcb;
            r_op_fcr  <= fcr;
            r_op_main <= i_main;
        end
    end

    always_comb begin
        case (r_op_mode)
            ckwb_pkg::MODE_MULTIPLY: n_direct = r_op_prod[15:8];
            ckwb_pkg::MODE_OVERLAY:
                n_direct = r_op_hi ? ckwb_pkg::FULL - r_op_prod[14:7] : r_op_prod[14:7];
            default: n_direct = r_op_add;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_st[0]      <= div4({9'b0, r_op_prod}, r_op_den);
            r_den[0]     <= r_op_den;
            r_ctl[0]     <= '{mode: r_op_mode, zero: r_op_zero, hi: r_op_hi, direct: n_direct};
            r_car[0]     <= '{main: r_op_main, lcb: mix_c(r_op_cbp, r_op_fcb),
                              lcr: mix_c(r_op_crp, r_op_fcr)};
        end
        for (int k = 1; k < DIV_STAGES; k++) begin
            if (i_en[k+1]) begin
                r_st[k]  <= div4(r_st[k-1], r_den[k-1]);
                r_den[k] <= r_den[k-1];
                r_ctl[k] <= r_ctl[k-1];
                r_car[k] <= r_car[k-1];
            end
        end
    end

    assign q    = r_st[DIV_STAGES-1][15:0];
    assign qsat = (|q[15:8]) ? ckwb_pkg::FULL : q[7:0];

    always_comb begin
        case (r_ctl[DIV_STAGES-1].mode) inside
            ckwb_pkg::MODE_DODGE:
                ly = r_ctl[DIV_STAGES-1].zero ? 8'd0 : ckwb_pkg::FULL - qsat;
            ckwb_pkg::MODE_BURN, ckwb_pkg::MODE_LIGHTEN_BURN:
                ly = r_ctl[DIV_STAGES-1].zero ? ckwb_pkg::FULL : qsat;
            default:
                ly = r_ctl[DIV_STAGES-1].direct;
        endcase
    end

    assign o_main = r_car[DIV_STAGES-1].main;
    assign o_mix  = '{y: ly, cb: r_car[DIV_STAGES-1].lcb, cr: r_car[DIV_STAGES-1].lcr};

endmodule

/* sv/ckwb_over.sv */
// final alpha blend of the main pixel over the layer mix, two stages
module ckwb_over (
    input  logic                i_clk,
    input  ckwb_pkg::t_stage_en i_en,
    input  logic [7:0]          i_alpha,
    input  ckwb_pkg::t_pixel    i_main,
    input  ckwb_pkg::t_pixel    i_mix,
    output ckwb_pkg::t_pixel    o_pixel
);

    logic [7:0]       inv;
    logic [16:0]      r_xy, r_xcb, r_xcr;
    logic             r_keyed, r_solo;
    ckwb_pkg::t_pixel r_main, r_mix, r_out;

    function automatic logic [7:0] round_div(input logic [16:0] x);
        logic [16:0] s;
        s = x + 17'd1 + 17'(x[16:8]);
        return s[15:8];
    endfunction

    assign inv = ckwb_pkg::FULL - i_alpha;

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_xy    <= 17'(i_mix.y * inv)  + 17'(i_main.y * i_alpha);
            r_xcb   <= 17'(i_mix.cb * inv) + 17'(i_main.cb * i_alpha);
            r_xcr   <= 17'(i_mix.cr * inv) + 17'(i_main.cr * i_alpha);
            r_keyed <= (i_alpha == ckwb_pkg::FULL);
            r_solo  <= (i_alpha == 8'd0);
            r_main  <= i_main;
            r_mix   <= i_mix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            if (r_keyed) begin
                r_out <= r_main;
            end else if (r_solo) begin
                r_out <= r_mix;
            end else begin
                r_out <= '{y: round_div(r_xy), cb: round_div(r_xcb), cr: round_div(r_xcr)};
            end
        end
    end

    assign o_pixel = r_out;

endmodule
